@@ sv/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, codes and constant functions for the extended Hamming
// SECDED codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int MAX_CODE_BITS = 64;
  localparam int WORD_W        = 64;
  localparam int CFG_W         = 6;
  localparam int POS_W         = 7;
  localparam int SYN_W         = 6;   // Hamming positions stay below 64
  localparam int STAT_W        = 2;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_CLEAN       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FIX_BIT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FIX_OVERALL = 2'd2;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] payload;
  } hsc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [POS_W-1:0]  error_position;
    logic [STAT_W-1:0] status;
  } hsc_out_t;

  // least r with 2^r >= d + r + 1
  function automatic int check_count(input int d);
    int r;
    r = 7;
    for (int i = 7; i >= 0; i--) begin
      if ((1 << i) >= d + i + 1) r = i;
    end
    return r;
  endfunction

  function automatic int max_data_bits();
    int best;
    best = 1;
    for (int k = 1; k < 64; k++) begin
      if (k + check_count(k) + 1 <= MAX_CODE_BITS) best = k;
    end
    return best;
  endfunction

  localparam int DATA_BITS_MAX = max_data_bits();

  function automatic logic [CFG_W-1:0] eff_data_bits(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] d;
    d = raw;
    if (d == '0) d = CFG_W'(1);
    if (int'(d) > DATA_BITS_MAX) d = CFG_W'(DATA_BITS_MAX);
    return d;
  endfunction

  // Hamming span m = d + r, at most 63
  function automatic logic [SYN_W-1:0] ham_span(input logic [CFG_W-1:0] d);
    int di;
    di = int'(d);
    return SYN_W'(di + check_count(di));
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(input logic [SYN_W-1:0] n);
    return ~({WORD_W{1'b1}} << n);
  endfunction

  // data bit k goes to the k-th position that is not a power of two
  function automatic logic [WORD_W-1:0] scatter(input logic [WORD_W-1:0] data);
    logic [WORD_W-1:0] w;
    int k;
    w = '0;
    k = 0;
    for (int pos = 1; pos <= WORD_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        w[pos-1] = data[k];
        k++;
      end
    end
    return w;
  endfunction

  // word bits whose one-based position has bit i set
  function automatic logic [WORD_W-1:0] group_mask(input int i);
    logic [WORD_W-1:0] msk;
    msk = '0;
    for (int pos = 1; pos < WORD_W; pos++) begin
      if (((pos >> i) & 1) != 0) msk[pos-1] = 1'b1;
    end
    return msk;
  endfunction

  localparam logic [CFG_W-1:0] DATA_BITS_RST = CFG_W'(57);

endpackage

@@ sv/hamming_secded_codec_core.sv @@
// ----------------------------------------------------------------------------
// hamming_secded_codec_core
// Extended Hamming SECDED encoder / single-error corrector, three-stage
// pipeline with valid/stall handshakes.
// ----------------------------------------------------------------------------
// One word enters per cycle while in_stall is low, and its result passes
// three register stages (scatter and mask, group parity trees, correction
// and assembly). Stages with no valid item take new data while later
// stages wait, so bubbles close up under output stall. data_bits (1..57,
// 0 reads as 1, larger values clamp to 57) is taken through the cfg
// channel, always ready; write it only while the pipeline is empty.
// Double errors are not flagged.
module hamming_secded_codec_core
  import hsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsc_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hsc_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  // configuration derived values
  logic [SYN_W-1:0]  span_r;      // m = d + r
  logic [WORD_W-1:0] dmask_r;     // low d bits
  logic [WORD_W-1:0] mmask_r;     // low m bits
  logic [CFG_W-1:0]  eff_d;
  logic [SYN_W-1:0]  eff_m;
  logic [WORD_W-1:0] nmask;

  assign cfg_ready = 1'b1;
  assign eff_d     = eff_data_bits(cfg_data);
  assign eff_m     = ham_span(eff_d);
  assign nmask     = {mmask_r[WORD_W-2:0], 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r  <= ham_span(DATA_BITS_RST);
      dmask_r <= low_mask(SYN_W'(DATA_BITS_RST));
      mmask_r <= low_mask(ham_span(DATA_BITS_RST));
    end else if (cfg_valid && cfg_ready) begin
      span_r  <= eff_m;
      dmask_r <= low_mask(eff_d);
      mmask_r <= low_mask(eff_m);
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: place data bits or mask the received word
  logic              func1_r;
  logic [WORD_W-1:0] word1_r;
  logic [WORD_W-1:0] word1_nxt;

  always_comb begin
    if (in_data.func == FUNC_ENCODE) begin
      word1_nxt = scatter(in_data.payload & dmask_r);
    end else begin
      word1_nxt = in_data.payload & nmask;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      func1_r <= in_data.func;
      word1_r <= word1_nxt;
    end
  end

  // stage 2: group parities (check bits or syndrome) and total parity
  logic              func2_r;
  logic [WORD_W-1:0] word2_r;
  logic [SYN_W-1:0]  grp2_r;
  logic              tot2_r;
  logic [SYN_W-1:0]  grp2_nxt;
  logic [WORD_W-1:0] ham1;

  assign ham1 = word1_r & mmask_r;  // overall bit stays out of the groups

  always_comb begin
    for (int i = 0; i < SYN_W; i++) begin
      grp2_nxt[i] = ^(ham1 & group_mask(i));
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      func2_r <= func1_r;
      word2_r <= word1_r;
      grp2_r  <= grp2_nxt;
      tot2_r  <= ^word1_r;
    end
  end

  // stage 3: insert check bits and overall parity, or correct
  hsc_out_t out_r;
  hsc_out_t out_nxt;

  always_comb begin
    logic [WORD_W-1:0] cw;
    cw      = word2_r;
    out_nxt = '0;
    if (func2_r == FUNC_ENCODE) begin
      for (int i = 0; i < SYN_W; i++) begin
        cw[(1 << i) - 1] = cw[(1 << i) - 1] | grp2_r[i];
      end
      cw[span_r] = tot2_r ^ (^grp2_r);
      out_nxt.result_word = cw;
    end else begin
      out_nxt.result_word = word2_r;
      if (tot2_r) begin
        if (grp2_r == '0) begin
          out_nxt.result_word    = word2_r ^ (WORD_W'(1) << span_r);
          out_nxt.error_position = POS_W'(span_r) + POS_W'(1);
          out_nxt.status         = STAT_FIX_OVERALL;
        end else if (grp2_r <= span_r) begin
          out_nxt.result_word    = word2_r ^ (WORD_W'(1) << (grp2_r - SYN_W'(1)));
          out_nxt.error_position = POS_W'(grp2_r);
          out_nxt.status         = STAT_FIX_BIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) out_r <= out_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

@@ dv/hamming_secded_codec_core_test.sv @@
// ----------------------------------------------------------------------------
// hamming_secded_codec_core_test
// Self-checking bench for the SECDED codec core: encodes and decodes words,
// with clean, single-, double- and high-bit-corrupted codewords, across a
// range of data lengths, and compares every transfer on the result side
// against an in-bench prediction under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module hamming_secded_codec_core_test;
  import hsc_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int PHASE_ITEMS  = 85;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 10;

  // Predicts each result and holds the ones still due from the core.
  class secded_ledger;
    logic [CFG_W-1:0] data_bits;
    hsc_out_t         due_results[$];
    int               longest_d;
    int               mismatches;
    int               matched;
    int               n_encode;
    int               n_decode;
    int               n_fix_bit;
    int               n_fix_overall;

    function new();
      data_bits     = CFG_W'(57);
      mismatches    = 0;
      matched       = 0;
      n_encode      = 0;
      n_decode      = 0;
      n_fix_bit     = 0;
      n_fix_overall = 0;
      longest_d     = 1;
      for (int k = 1; k <= 63; k++) begin
        if (k + checks_for(k) + 1 <= MAX_CODE_BITS) longest_d = k;
      end
    endfunction

    function int checks_for(int d);
      int r;
      r = 0;
      while ((1 << r) < d + r + 1) r++;
      return r;
    endfunction

    function int data_len();
      int d;
      d = int'(data_bits);
      if (d < 1) d = 1;
      if (d > longest_d) d = longest_d;
      return d;
    endfunction

    function int code_len();
      int d;
      d = data_len();
      return d + checks_for(d) + 1;
    endfunction

    function hsc_out_t secded_calc(hsc_in_t item);
      hsc_out_t          res;
      logic [WORD_W-1:0] w;
      logic              par;
      int                d, r, m, n, k, syn, err;
      d   = data_len();
      r   = checks_for(d);
      m   = d + r;
      n   = m + 1;
      err = 0;
      res = '0;
      res.status = STAT_CLEAN;
      if (item.func == FUNC_ENCODE) begin
        w = '0;
        k = 0;
        for (int pos = 1; pos <= m; pos++) begin
          if ((pos & (pos - 1)) != 0) begin
            w[pos-1] = item.payload[k];
            k++;
          end
        end
        for (int i = 0; i < r; i++) begin
          par = 1'b0;
          for (int pos = 1; pos <= m; pos++) begin
            if (((pos >> i) & 1) != 0) par ^= w[pos-1];
          end
          if (par) w[(1 << i) - 1] = 1'b1;
        end
        w[m] = ^w;
      end else begin
        w = (n >= WORD_W) ? item.payload : (item.payload & ((64'd1 << n) - 64'd1));
        if (^w) begin
          syn = 0;
          for (int pos = 1; pos <= m; pos++) begin
            if (w[pos-1]) syn ^= pos;
          end
          if (syn == 0) begin
            w[m] = ~w[m];
            err = n;
            res.status = STAT_FIX_OVERALL;
          end else if (syn <= m) begin
            w[syn-1] = ~w[syn-1];
            err = syn;
            res.status = STAT_FIX_BIT;
          end
          // a syndrome past the codeword leaves the word as received
        end
      end
      res.result_word    = w;
      res.error_position = POS_W'(err);
      return res;
    endfunction

    function void note_word(hsc_in_t item);
      hsc_out_t res;
      res = secded_calc(item);
      due_results.push_back(res);
      if (item.func == FUNC_ENCODE) n_encode++;
      else n_decode++;
      if (res.status == STAT_FIX_BIT) n_fix_bit++;
      if (res.status == STAT_FIX_OVERALL) n_fix_overall++;
    endfunction

    function void check_word(hsc_out_t got);
      hsc_out_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result word=%h pos=%0d status=%0d",
                   got.result_word, got.error_position, got.status);
        return;
      end
      want = due_results.pop_front();
      if (got.result_word !== want.result_word ||
          got.error_position !== want.error_position ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: mismatch exp %h/%0d/%0d got %h/%0d/%0d (word/pos/status)",
                   want.result_word, want.error_position, want.status,
                   got.result_word, got.error_position, got.status);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  hsc_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  hsc_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  secded_ledger ledger = new();
  int           cycles       = 0;
  int           hold_seq     = 0;
  int           n_cfg_writes = 0;

  hamming_secded_codec_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycles, ledger.due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: every transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_word(out_data);
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int hold_seen;
    int mode;
    int span;
    hold_seen = 0;
    mode      = 0;
    span      = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 80);
        end
        span--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 6);
          end
          default: begin
            out_stall <= ((cycles % 7) < 3);
          end
        endcase
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] codeword_of(logic [WORD_W-1:0] data);
    hsc_in_t  item;
    hsc_out_t res;
    item.func    = FUNC_ENCODE;
    item.payload = data;
    res = ledger.secded_calc(item);
    return res.result_word;
  endfunction

  // caller stands at a rising edge; returns at the edge of the transfer
  task automatic send_item(logic func, logic [WORD_W-1:0] payload);
    hsc_in_t item;
    item.func    = func;
    item.payload = payload;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    ledger.note_word(item);
  endtask

  task automatic pause_input(int gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ledger.due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_data_bits(logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.data_bits = val;
    n_cfg_writes++;
  endtask

  task automatic offer_random();
    logic [WORD_W-1:0] cw;
    int                sel;
    int                flips;
    int                n;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      send_item(FUNC_ENCODE, rand64());
    end else if (sel < 85) begin
      n  = ledger.code_len();
      cw = codeword_of(rand64());
      sel = $urandom_range(0, 9);
      flips = (sel < 3) ? 0 : (sel < 8) ? 1 : 2;
      for (int j = 0; j < flips; j++) begin
        sel = $urandom_range(1, n);
        cw[sel-1] = ~cw[sel-1];
      end
      // junk above the codeword must be ignored
      if (n < WORD_W && $urandom_range(0, 3) == 0)
        cw |= rand64() & ~((64'd1 << n) - 64'd1);
      send_item(FUNC_DECODE, cw);
    end else begin
      send_item(logic'($urandom_range(0, 1)), rand64());
    end
  endtask

  initial begin
    logic [CFG_W-1:0]  plan[12];
    logic [WORD_W-1:0] cw;
    int                burst;
    int                sent;
    bit                no_gaps;

    plan = '{6'd0, 6'd1, 6'd63, 6'd58, 6'd4, 6'd11, 6'd26, 6'd32, 6'd57, 6'd40,
             6'd5, 6'd0};
    plan[11] = CFG_W'($urandom_range(0, 63));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, at the reset data length
    send_item(FUNC_ENCODE, 64'h0);
    send_item(FUNC_ENCODE, '1);
    send_item(FUNC_ENCODE, 64'h5555_5555_5555_5555);
    send_item(FUNC_ENCODE, 64'h0000_0000_0000_0001);
    send_item(FUNC_ENCODE, 64'h0100_0000_0000_0000);
    cw = codeword_of(64'h0123_4567_89ab_cdef);
    send_item(FUNC_DECODE, cw);
    send_item(FUNC_DECODE, cw ^ 64'h0000_0000_0000_0004);   // data bit
    send_item(FUNC_DECODE, cw ^ 64'h0000_0000_0000_0001);   // check bit at 1
    send_item(FUNC_DECODE, cw ^ 64'h8000_0000_0000_0000);   // overall bit
    send_item(FUNC_DECODE, cw ^ 64'h4000_0000_0000_0000);   // last Hamming bit
    send_item(FUNC_DECODE, cw ^ 64'h0000_0000_0000_0030);   // double error
    send_item(FUNC_DECODE, 64'h0);
    send_item(FUNC_DECODE, '1);
    drain_results();

    // short code: syndromes past the codeword, and ignored high bits
    write_data_bits(CFG_W'(2));
    send_item(FUNC_DECODE, 64'h0000_0000_0000_000b);        // syndrome 7
    send_item(FUNC_DECODE, 64'h0000_0000_0000_002a);        // syndrome 6
    send_item(FUNC_ENCODE, '1);
    send_item(FUNC_DECODE, 64'hffff_ffff_ffff_ffc0);
    send_item(FUNC_DECODE, codeword_of(64'h3) ^ 64'h20);
    drain_results();

    for (int p = 0; p < 12; p++) begin
      write_data_bits(plan[p]);
      no_gaps = (p % 4 == 1);
      sent = 0;
      if (p == 3) begin
        // receiver holds off while input keeps coming
        hold_seq <= hold_seq + 1;
        for (int j = 0; j < 40; j++) offer_random();
        sent = 40;
      end
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 20);
        for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
          offer_random();
          sent++;
        end
        if (p == 6 && sent >= PHASE_ITEMS / 2 && sent - burst < PHASE_ITEMS / 2)
          drain_results();
        else if (!no_gaps && $urandom_range(0, 2) != 0)
          pause_input($urandom_range(1, 8));
      end
      drain_results();
    end

    $display("Covered %0d encodes and %0d decodes over %0d data-length writes,",
             ledger.n_encode, ledger.n_decode, n_cfg_writes);
    $display("with %0d codeword-bit and %0d overall-bit corrections; %0d results matched.",
             ledger.n_fix_bit, ledger.n_fix_overall, ledger.matched);
    if (ledger.due_results.size() != 0)
      $display("ERROR: %0d results never arrived", ledger.due_results.size());
    if (ledger.mismatches == 0 && ledger.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ hamming_secded_codec_core.f @@
sv/hsc_pkg.sv
sv/hamming_secded_codec_core.sv
dv/hamming_secded_codec_core_test.sv
